/* hdl/dqnr_pkg.sv */
// ----------------------------------------------------------------------------
// dqnr_pkg: shared types and constants of the near-end-removal deque
// Operation codes, cell command bundle and the elaboration-time helpers
// that size the registered select tree.
// ----------------------------------------------------------------------------
package dqnr_pkg;

  // Fixed widths of the channel fields.
  localparam int OP_W    = 3;
  localparam int VALUE_W = 16;

  // Fan-in of one node of the select tree.
  localparam int TREE_RADIX = 32;

  // Operation codes carried by an input word.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT1 = 3'd2,
    OP_POP_FRONT2 = 3'd3,
    OP_POP_FRONT3 = 3'd4,
    OP_POP_BACK1  = 3'd5,
    OP_POP_BACK2  = 3'd6,
    OP_POP_BACK3  = 3'd7
  } op_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic push_front;  // every cell takes its front neighbor
    logic push_back;   // the addressed cell takes the pushed value
    logic remove;      // cells at or behind the address take their back neighbor
  } cell_cmd_t;

  // Number of nodes on a given level of the tree; level zero is the leaves.
  function automatic int tree_level_width(int n, int lvl);
    int w;
    w = n;
    for (int i = 0; i < lvl; i++) begin
      w = (w + TREE_RADIX - 1) / TREE_RADIX;
    end
    return w;
  endfunction

  // Number of registered levels above the leaves.
  function automatic int tree_levels(int n);
    int w;
    int l;
    w = n;
    l = 0;
    while (w > 1) begin
      w = (w + TREE_RADIX - 1) / TREE_RADIX;
      l++;
    end
    if (l == 0) begin
      l = 1;
    end
    return l;
  endfunction

  // Position of the first node of a level in the flat node array.
  function automatic int tree_offset(int n, int lvl);
    int off;
    off = 0;
    for (int i = 1; i < lvl; i++) begin
      off += tree_level_width(n, i);
    end
    return off;
  endfunction

endpackage

/* hdl/dqnr_in_if.sv */
// ----------------------------------------------------------------------------
// dqnr_in_if: command channel of the deque
// One word carries an operation code and the value to push.
// ----------------------------------------------------------------------------
interface dqnr_in_if;
  logic                           valid;
  logic                           ready;
  logic [dqnr_pkg::OP_W-1:0]      operation;
  logic [dqnr_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

/* hdl/dqnr_out_if.sv */
// ----------------------------------------------------------------------------
// dqnr_out_if: result channel of the deque
// One word carries a removed value and an error flag.
// ----------------------------------------------------------------------------
interface dqnr_out_if;
  logic                           valid;
  logic                           ready;
  logic [dqnr_pkg::VALUE_W-1:0]   value_res;
  logic                           error;

  modport source (output valid, output value_res, output error, input ready);
  modport sink   (input valid, input value_res, input error, output ready);
endinterface

/* hdl/deque_with_near_end_removal.sv */
// ----------------------------------------------------------------------------
// deque_with_near_end_removal: bounded deque with removal near either end
// A row of DEPTH cells holds the elements front first; a registered OR tree
// reads the element that a removal takes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries command words (operation, value); out_o carries result words
//   (value_res, error). Both use valid/ready; a word moves when both are high.
//   Pushes give no result word unless the store is full (error word then).
//   Removals always give one result word, an error word if too few elements.
//   One command is worked at a time. A removal reads its element through the
//   radix-32 select tree over the cells: a select register in each cell, then
//   one registered level for DEPTH <= 32, two for DEPTH <= 1024 and one more
//   for each further factor of 32. The element read is registered and then
//   loaded into an output register, so the next command is accepted while
//   the receiver stalls; a second result waits until that register frees up,
//   which adds the stall to that command's time.
//   Reset clears the element count and the output valid; cell contents are
//   not reset and only live elements are ever read.
// ----------------------------------------------------------------------------
module deque_with_near_end_removal #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dqnr_in_if.sink        in_i,
  dqnr_out_if.source     out_o
);

  localparam int POS_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int LEVELS  = dqnr_pkg::tree_levels(DEPTH);
  localparam int WAIT_W  = $clog2(LEVELS + 2);
  localparam int MAXW    = (VALUE_WIDTH > dqnr_pkg::VALUE_W) ? VALUE_WIDTH
                                                             : dqnr_pkg::VALUE_W;
  localparam logic [WAIT_W-1:0]  WAIT_LAST = WAIT_W'(LEVELS + 1);
  localparam logic [COUNT_W-1:0] FULL      = COUNT_W'(DEPTH);

  // Control states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                         state_q, state_d;
  logic [COUNT_W-1:0]             count_q, count_d;
  dqnr_pkg::op_e                  op_q;
  logic [dqnr_pkg::VALUE_W-1:0]   val_q;
  logic [POS_W-1:0]               pos_q, pos_d;
  logic [WAIT_W-1:0]              wait_q, wait_d;
  logic [dqnr_pkg::VALUE_W-1:0]   res_val_q, res_val_d;
  logic                           res_err_q, res_err_d;
  logic                           out_valid_q, out_valid_d;
  logic [dqnr_pkg::VALUE_W-1:0]   out_val_q;
  logic                           out_err_q;
  logic                           out_load;

  logic                           in_accept;
  logic                           wait_last;
  logic                           is_push;
  logic                           is_front;
  logic [1:0]                     rem_k;
  logic [COUNT_W-1:0]             back_pos;

  dqnr_pkg::cell_cmd_t            cmd;
  logic [POS_W-1:0]               cell_pos;
  logic [MAXW-1:0]                push_ext;
  logic [VALUE_WIDTH-1:0]         push_val;
  logic [VALUE_WIDTH-1:0]         val_w  [DEPTH];
  logic [VALUE_WIDTH-1:0]         sel_w  [DEPTH];
  logic [VALUE_WIDTH-1:0]         root;
  logic [MAXW-1:0]                root_ext;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign wait_last  = (wait_q == WAIT_LAST);

  // Operation decode: push or removal, end and distance from that end.
  always_comb begin
    is_push  = 1'b0;
    is_front = 1'b0;
    rem_k    = 2'd0;
    unique case (op_q) inside
      dqnr_pkg::OP_PUSH_FRONT, dqnr_pkg::OP_PUSH_BACK: begin
        is_push = 1'b1;
      end
      dqnr_pkg::OP_POP_FRONT1: begin
        is_front = 1'b1;
      end
      dqnr_pkg::OP_POP_FRONT2: begin
        is_front = 1'b1;
        rem_k    = 2'd1;
      end
      dqnr_pkg::OP_POP_FRONT3: begin
        is_front = 1'b1;
        rem_k    = 2'd2;
      end
      dqnr_pkg::OP_POP_BACK1: begin
        rem_k = 2'd0;
      end
      dqnr_pkg::OP_POP_BACK2: begin
        rem_k = 2'd1;
      end
      dqnr_pkg::OP_POP_BACK3: begin
        rem_k = 2'd2;
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
  end

  assign back_pos = count_q - COUNT_W'(1) - COUNT_W'(rem_k);

  // Pushed value in the storage width, removed value in the channel width.
  assign push_ext = MAXW'(val_q);
  assign push_val = push_ext[VALUE_WIDTH-1:0];
  assign root_ext = MAXW'(root);

  // A back push addresses the first free cell; everything else uses pos_q.
  assign cell_pos = cmd.push_back ? count_q[POS_W-1:0] : pos_q;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    wait_d    = wait_q;
    res_val_d = res_val_q;
    res_err_d = res_err_q;
    cmd       = '0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_push) begin
          if (count_q == FULL) begin
            res_val_d = '0;
            res_err_d = 1'b1;
            state_d   = ST_EMIT;
          end else begin
            cmd.push_front = (op_q == dqnr_pkg::OP_PUSH_FRONT);
            cmd.push_back  = (op_q == dqnr_pkg::OP_PUSH_BACK);
            count_d        = count_q + COUNT_W'(1);
            state_d        = ST_IDLE;
          end
        end else if (count_q <= COUNT_W'(rem_k)) begin
          res_val_d = '0;
          res_err_d = 1'b1;
          state_d   = ST_EMIT;
        end else begin
          pos_d   = is_front ? POS_W'(rem_k) : back_pos[POS_W-1:0];
          wait_d  = '0;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // The tree root shows the addressed element once the leaves and all
        // levels have settled on pos_q; then close the gap.
        if (wait_last) begin
          res_val_d  = root_ext[dqnr_pkg::VALUE_W-1:0];
          res_err_d  = 1'b0;
          cmd.remove = 1'b1;
          count_d    = count_q - COUNT_W'(1);
          state_d    = ST_EMIT;
        end else begin
          wait_d = wait_q + WAIT_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid: held until the receiver takes the word.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= dqnr_pkg::op_e'(in_i.operation);
      val_q <= in_i.value;
    end
    pos_q     <= pos_d;
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_err_q <= res_err_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_res = out_val_q;
  assign out_o.error     = out_err_q;

  // Row of cells, front element in cell zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] front_v;
    logic [VALUE_WIDTH-1:0] back_v;

    if (i == 0) begin : g_first
      assign front_v = push_val;
    end else begin : g_mid_f
      assign front_v = val_w[i - 1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign back_v = val_w[i];
    end else begin : g_mid_b
      assign back_v = val_w[i + 1];
    end

    dqnr_cell #(
      .POS_W (POS_W),
      .VW    (VALUE_WIDTH),
      .IDX   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (cell_pos),
      .push_val_i (push_val),
      .front_i    (front_v),
      .back_i     (back_v),
      .val_o      (val_w[i]),
      .sel_o      (sel_w[i])
    );
  end

  dqnr_tree #(
    .N (DEPTH),
    .W (VALUE_WIDTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (sel_w),
    .root_o (root)
  );

  // A command is worked alone: no new word right after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_i.ready)
    else $error("command accepted while previous one still in progress");

  // An error word never carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_val_q == '0))
    else $error("error result with nonzero value");

  // A completed removal takes exactly one element out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && wait_last) |=> (count_q == $past(count_q) - COUNT_W'(1)))
    else $error("removal did not decrement the element count");

  // The element count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("element count beyond capacity");

endmodule

/* hdl/dqnr_cell.sv */
// ----------------------------------------------------------------------------
// dqnr_cell: one storage cell of the deque row
// Holds the element at a fixed distance from the front and trades it with
// its neighbors on pushes and removals. Also presents its value on a
// registered select output when the broadcast address matches.
// ----------------------------------------------------------------------------
module dqnr_cell #(
  parameter int POS_W = 10,
  parameter int VW    = 16,
  parameter int IDX   = 0
) (
  input  logic                      clk_i,
  input  dqnr_pkg::cell_cmd_t       cmd_i,
  input  logic [POS_W-1:0]          pos_i,
  input  logic [VW-1:0]             push_val_i,
  input  logic [VW-1:0]             front_i,
  input  logic [VW-1:0]             back_i,
  output logic [VW-1:0]             val_o,
  output logic [VW-1:0]             sel_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [VW-1:0] val_q, val_d;
  logic [VW-1:0] sel_q;
  logic          hit;

  assign hit = (pos_i == MY_POS);

  // Next element: shift back on a front push, load on a matching back push,
  // shift toward the front behind a removed element.
  always_comb begin
    val_d = val_q;
    if (cmd_i.push_front) begin
      val_d = front_i;
    end else if (cmd_i.push_back && hit) begin
      val_d = push_val_i;
    end else if (cmd_i.remove && (pos_i <= MY_POS)) begin
      val_d = back_i;
    end
  end

  // Element storage and the leaf of the select tree.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sel_q <= hit ? val_q : '0;
  end

  assign val_o = val_q;
  assign sel_o = sel_q;

endmodule

/* hdl/dqnr_tree.sv */
// ----------------------------------------------------------------------------
// dqnr_tree: registered OR tree over the cell select outputs
// At most one leaf is nonzero, so OR-ing the leaves picks out the addressed
// element. Every level is registered.
// ----------------------------------------------------------------------------
module dqnr_tree #(
  parameter int N = 1024,
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic [W-1:0]   leaf_i [N],
  output logic [W-1:0]   root_o
);

  localparam int R      = dqnr_pkg::TREE_RADIX;
  localparam int LEVELS = dqnr_pkg::tree_levels(N);
  localparam int TOTAL  = dqnr_pkg::tree_offset(N, LEVELS + 1);

  logic [W-1:0] node_w [TOTAL];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int PW   = dqnr_pkg::tree_level_width(N, l - 1);
    localparam int CW   = dqnr_pkg::tree_level_width(N, l);
    localparam int OFF  = dqnr_pkg::tree_offset(N, l);
    localparam int POFF = dqnr_pkg::tree_offset(N, l - 1);

    for (genvar j = 0; j < CW; j++) begin : g_node
      logic [W-1:0] kids [R];
      logic [W-1:0] acc;
      logic [W-1:0] node_q;

      // Gather up to one radix worth of children from the level below.
      for (genvar c = 0; c < R; c++) begin : g_kid
        if (j * R + c < PW) begin : g_on
          if (l == 1) begin : g_leaf
            assign kids[c] = leaf_i[j * R + c];
          end else begin : g_inner
            assign kids[c] = node_w[POFF + j * R + c];
          end
        end else begin : g_off
          assign kids[c] = '0;
        end
      end

      always_comb begin
        acc = '0;
        for (int c = 0; c < R; c++) begin
          acc = acc | kids[c];
        end
      end

      always_ff @(posedge clk_i) begin
        node_q <= acc;
      end

      assign node_w[OFF + j] = node_q;
    end
  end

  assign root_o = node_w[TOTAL - 1];

endmodule

/* bench/tb_deque_with_near_end_removal.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deque_with_near_end_removal: self-checking bench of the bounded deque
// A queue-based shadow of the deque predicts the result word, if any, of every
// accepted command word. Each result word is checked field by field against
// the oldest prediction. The command words are a short directed list and then
// random segments: mixed walks near empty, a fill past full, and a drain.
// Both channels idle at random in the first two phases; the third has no idling.
// ----------------------------------------------------------------------------
module tb_deque_with_near_end_removal;

  localparam int     DEPTH        = 1024;
  localparam int     VALUE_W      = dqnr_pkg::VALUE_W;
  localparam int     CLK_HALF     = 4;
  localparam int     RESET_CYCLES = 7;
  localparam int     DRAIN_CYCLES = 20;
  localparam longint CYCLE_LIMIT  = 500000;

  typedef struct {
    dqnr_pkg::op_e      op;
    logic [VALUE_W-1:0] value;
    bit                 wait_empty;  // hold this word until no result is pending
  } cmd_word_t;

  typedef struct {
    logic [VALUE_W-1:0] value_res;
    logic               error;
  } result_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dqnr_in_if  cmd_if ();
  dqnr_out_if res_if ();

  deque_with_near_end_removal dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  cmd_word_t          cmd_q[$];       // command words not yet driven
  result_word_t       expected_q[$];  // predicted result words, oldest first
  logic [VALUE_W-1:0] shadow_q[$];    // shadow deque, front element first

  int     words_queued  = 0;
  int     words_driven  = 0;
  int     words_taken   = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     mismatches    = 0;
  longint cycles        = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  // Print one line per failure and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Update the shadow deque with one accepted command word and record the
  // result word it causes, if any.
  task automatic predict_word(input dqnr_pkg::op_e op, input logic [VALUE_W-1:0] value);
    int           pos;
    result_word_t res;
    res.value_res = '0;
    res.error     = 1'b0;
    case (op)
      dqnr_pkg::OP_PUSH_FRONT, dqnr_pkg::OP_PUSH_BACK: begin
        if (shadow_q.size() >= DEPTH) begin
          // Full store: the value is dropped with an error word.
          res.error = 1'b1;
          expected_q.push_back(res);
        end else if (op == dqnr_pkg::OP_PUSH_FRONT) begin
          shadow_q.push_front(value);
        end else begin
          shadow_q.push_back(value);
        end
      end
      default: begin
        if (op <= dqnr_pkg::OP_POP_FRONT3) begin
          pos = int'(op) - int'(dqnr_pkg::OP_POP_FRONT1);
        end else begin
          pos = int'(op) - int'(dqnr_pkg::OP_POP_BACK1);
        end
        if (shadow_q.size() <= pos) begin
          // Too few elements: error word and no change.
          res.error = 1'b1;
        end else begin
          if (op >= dqnr_pkg::OP_POP_BACK1) begin
            pos = shadow_q.size() - 1 - pos;
          end
          res.value_res = shadow_q[pos];
          shadow_q.delete(pos);
        end
        expected_q.push_back(res);
      end
    endcase
  endtask

  task automatic add_word(input dqnr_pkg::op_e op, input logic [VALUE_W-1:0] value,
                          input bit wait_empty);
    cmd_word_t w;
    w.op         = op;
    w.value      = value;
    w.wait_empty = wait_empty;
    cmd_q.push_back(w);
    words_queued++;
  endtask

  // Random command words; push_pct sets the share of pushes and so the drift
  // of the fill level.
  task automatic add_random(input int n, input int push_pct);
    dqnr_pkg::op_e op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct) begin
        op = dqnr_pkg::op_e'($urandom_range(dqnr_pkg::OP_PUSH_BACK,
                                            dqnr_pkg::OP_PUSH_FRONT));
      end else begin
        op = dqnr_pkg::op_e'($urandom_range(dqnr_pkg::OP_POP_BACK3,
                                            dqnr_pkg::OP_POP_FRONT1));
      end
      add_word(op, VALUE_W'($urandom_range(16'hFFFF, 0)),
               (i == 0) || ($urandom_range(99) == 0));
    end
  endtask

  // Wait until every queued word is taken and every result word has come.
  task automatic wait_idle();
    while (words_taken != words_queued || expected_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: command words and result ready change on the falling edge.
  always @(negedge clk_i) begin
    cmd_word_t cur;
    bit        start;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      // A new word goes out only once the current one has been taken.
      if (!cmd_if.valid || words_taken == words_driven) begin
        start = (cmd_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (start && cmd_q[0].wait_empty && expected_q.size() != 0) begin
          start = 1'b0;
        end
        if (start) begin
          cur = cmd_q[0];
          cmd_q.delete(0);
          cmd_if.operation <= cur.op;
          cmd_if.value     <= cur.value;
          words_driven++;
        end
        cmd_if.valid <= start;
      end
    end
  end

  // Monitor: both channels are sampled on the rising edge.
  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_deque_with_near_end_removal NOT OK");
      $finish;
    end else if (rst_ni) begin
      cycles++;
      if (cmd_if.valid && cmd_if.ready) begin
        predict_word(dqnr_pkg::op_e'(cmd_if.operation), cmd_if.value);
        words_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: value_res %0h error %0b",
                                    res_if.value_res, res_if.error));
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (res_if.value_res !== want.value_res) begin
            report_mismatch($sformatf("value_res %0h, expected %0h",
                                      res_if.value_res, want.value_res));
          end
          if (res_if.error !== want.error) begin
            report_mismatch($sformatf("error %0b, expected %0b",
                                      res_if.error, want.error));
          end
        end
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    cmd_if.valid     = 1'b0;
    cmd_if.operation = dqnr_pkg::OP_PUSH_FRONT;
    cmd_if.value     = '0;
    res_if.ready     = 1'b0;
    send_idle_pct    = 6;
    recv_idle_pct    = 75;

    // Removals on an empty deque.
    add_word(dqnr_pkg::OP_POP_FRONT1, 16'hFFFF, 1'b0);
    add_word(dqnr_pkg::OP_POP_FRONT2, 16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_FRONT3, 16'h5A5A, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK1,  16'hFFFF, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK2,  16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK3,  16'hA5A5, 1'b0);
    // Three elements, then inner and outer removals down to empty.
    add_word(dqnr_pkg::OP_PUSH_BACK,  16'hFFFF, 1'b0);
    add_word(dqnr_pkg::OP_PUSH_FRONT, 16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_PUSH_BACK,  16'h0001, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK3,  16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_FRONT3, 16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK3,  16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_FRONT2, 16'hFFFF, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK2,  16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK1,  16'h0000, 1'b0);
    // Four elements; the inner removals close the gap by moving the later elements forward.
    add_word(dqnr_pkg::OP_PUSH_FRONT, 16'hAAAA, 1'b0);
    add_word(dqnr_pkg::OP_PUSH_FRONT, 16'h5555, 1'b0);
    add_word(dqnr_pkg::OP_PUSH_BACK,  16'h8000, 1'b0);
    add_word(dqnr_pkg::OP_PUSH_BACK,  16'h7FFF, 1'b0);
    add_word(dqnr_pkg::OP_POP_FRONT3, 16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK2,  16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_FRONT1, 16'h0000, 1'b0);
    add_word(dqnr_pkg::OP_POP_BACK1,  16'h0000, 1'b0);
    add_random(300, 50);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_idle();

    // Slow sender, busy receiver.
    send_idle_pct = 75;
    recv_idle_pct = 6;
    add_random(300, 50);
    wait_idle();

    // No idling: fill past full, then drain part of the way.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(1100, 98);
    add_random(300, 10);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_deque_with_near_end_removal OK");
    end else begin
      $display("tb_deque_with_near_end_removal NOT OK");
    end
    $finish;
  end

endmodule
